>>> src/xcpc_pkg.sv
// Package for the xorshift chained pixel cipher: constants, types and the generator step.
`default_nettype none
package xcpc_pkg;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned STEP_W     = 21;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(MAX_PIXELS);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SEED         = 2'd0;
  localparam cfg_idx_t REG_START_VALUE  = 2'd1;
  localparam cfg_idx_t REG_PIXEL_COUNT  = 2'd2;
  localparam cfg_idx_t REG_DECRYPT_MODE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_WARM = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // One xorshift32 step, shifts 13 / 17 / 5.
  function automatic logic [31:0] xs_step(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage
`default_nettype wire

>>> src/xcpc_in_if.sv
// Input pixel channel: valid/ready handshake with the pixel and frame marker.
`default_nettype none
interface xcpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface
`default_nettype wire

>>> src/xcpc_out_if.sv
// Output pixel channel: valid/ready handshake with the ciphered pixel.
`default_nettype none
interface xcpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

>>> src/xorshift_chained_pixel_cipher.sv
// Top level: xorshift32 keystream, XOR-chained pixel cipher with one shared step unit.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   pix_in   | in  | valid/ready   | red_in, green_in, blue_in, frame_start
//   pix_out  | out | valid/ready   | red_out, green_out, blue_out
//   cfg      | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
// A plain pixel passes through accept, one generator step and result load.
// A frame-start pixel runs min(pixel_count, 2^20) warm-up steps, then the result
// load; the single xorshift step unit is reused once per warm-up step.
// The result register holds one pixel, so the next item is taken while it waits.
// rst is synchronous: config returns to seed 1, start_value 0, pixel_count 1, encrypt.
// A stalled pix_out holds the block in its result-load state until space frees up.
`default_nettype none
module xorshift_chained_pixel_cipher
  import xcpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire cfg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  xcpc_in_if.sink                    pix_in,
  xcpc_out_if.source                 pix_out
);

  // configuration
  logic [31:0]       seed;
  logic [31:0]       start_value;
  logic [STEP_W-1:0] pixel_count;
  logic              decrypt_mode;

  // datapath
  state_t            state;
  logic [31:0]       gen;
  logic [23:0]       chain;
  logic [23:0]       pix;
  logic [STEP_W-1:0] remaining;
  logic              out_valid;
  logic [23:0]       out_pix;

  logic              in_fire;
  logic              out_free;
  logic [31:0]       gen_next;
  logic [STEP_W-1:0] steps;
  logic [23:0]       res;
  logic [7:0]        sb;

  assign in_fire  = pix_in.valid && pix_in.ready;
  assign out_free = !out_valid || pix_out.ready;
  assign gen_next = xs_step(gen);
  assign steps    = (pixel_count > MAX_STEPS) ? MAX_STEPS : pixel_count;
  assign res      = pix ^ chain ^ gen[23:0];
  assign sb       = start_value[7:0];

  assign pix_in.ready      = (state == S_IDLE);
  assign pix_out.valid     = out_valid;
  assign pix_out.red_out   = out_pix[7:0];
  assign pix_out.green_out = out_pix[15:8];
  assign pix_out.blue_out  = out_pix[23:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= 32'd1;
      start_value  <= 32'd0;
      pixel_count  <= STEP_W'(1);
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:         seed         <= cfg_data;
        REG_START_VALUE:  start_value  <= cfg_data;
        REG_PIXEL_COUNT:  pixel_count  <= cfg_data[STEP_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen       <= 32'd0;
      chain     <= 24'd0;
      out_valid <= 1'b0;
      remaining <= '0;
    end else begin
      // in S_EMIT the load below owns out_valid
      if (out_valid && pix_out.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pix <= {pix_in.blue_in, pix_in.green_in, pix_in.red_in};
            if (pix_in.frame_start) begin
              gen       <= seed;
              chain     <= {sb, sb, sb};
              remaining <= steps;
              state     <= (steps == '0) ? S_EMIT : S_WARM;
            end else begin
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          gen   <= gen_next;
          state <= S_EMIT;
        end
        S_WARM: begin
          gen       <= gen_next;
          remaining <= remaining - STEP_W'(1);
          if (remaining == STEP_W'(1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_pix   <= res;
            out_valid <= 1'b1;
            chain     <= decrypt_mode ? pix : res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !pix_in.ready)
    else $error("block still ready after taking an item");

  a_warm_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_WARM) && (remaining == STEP_W'(1)) |=> (state == S_EMIT))
    else $error("warm-up did not end on its last step");

  a_warm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WARM) |-> (remaining != '0))
    else $error("warm-up running with no steps left");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && out_free |=> pix_out.valid && (state == S_IDLE))
    else $error("result not loaded when output had room");
`endif

endmodule
`default_nettype wire
